FILE: src/bedc_pkg.sv
// ----------------------------------------------------------------------------
// bedc_pkg
// Shared types and constants for the button edge and double-click detector.
// ----------------------------------------------------------------------------
package bedc_pkg;

  // Width of the level and mask fields
  localparam int unsigned LEVEL_WIDTH = 8;
  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  // Register index taken from the word address bit
  localparam logic REG_WINDOW = 1'b0;

  // Reset value of the double-click window
  localparam logic [TIME_WIDTH-1:0] WINDOW_RESET = 32'd500;

  // Click count codes
  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Input request
  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] button_levels;
    logic [TIME_WIDTH-1:0]  now_time;
  } in_req_t;

  // Result request
  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] down_mask;
    logic [LEVEL_WIDTH-1:0] up_mask;
    logic [LEVEL_WIDTH-1:0] held_mask;
    logic [LEVEL_WIDTH-1:0] double_click_mask;
  } out_req_t;

  // Per-button findings handed from a lane to the merge stage
  typedef struct packed {
    logic down;
    logic up;
    logic held;
    logic dbl;
  } lane_flags_t;

endpackage

FILE: src/bedc_lane.sv
// ----------------------------------------------------------------------------
// bedc_lane
// One button: edge detection, click counter and first-click timestamp.
// ----------------------------------------------------------------------------
module bedc_lane
  import bedc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  level,
  input  logic [TIME_WIDTH-1:0] now_time,
  input  logic [TIME_WIDTH-1:0] window,
  output lane_flags_t           flags
);

  logic                  prev_r, prev_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] first_r, first_nxt;

  logic                  is_down, is_up;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired, in_window;
  logic [1:0]            cnt_eff, cnt_base;

  // Edges against the previous sample
  assign is_down = level & ~prev_r;
  assign is_up   = prev_r & ~level;

  // Wrap-around elapsed time
  assign elapsed   = now_time - first_r;
  assign expired   = (elapsed >= window);
  assign in_window = (elapsed <= window);

  // An out-of-range count behaves as a full count
  assign cnt_eff  = (cnt_r > CNT_TWO) ? CNT_TWO : cnt_r;
  assign cnt_base = ((cnt_eff == CNT_ONE) && expired) ? CNT_ZERO : cnt_eff;

  // Count and timestamp update
  always_comb begin
    prev_nxt   = level;
    cnt_nxt    = cnt_eff;
    first_nxt  = first_r;
    flags.down = is_down;
    flags.held = prev_r & level;
    flags.up   = is_up;
    flags.dbl  = 1'b0;
    if (is_down) begin
      if (cnt_base == CNT_TWO) begin
        cnt_nxt = CNT_TWO;
      end else begin
        cnt_nxt = cnt_base + 2'd1;
      end
      if (cnt_base == CNT_ZERO) begin
        first_nxt = now_time;
      end
    end else if (is_up) begin
      if (cnt_eff == CNT_ONE) begin
        cnt_nxt = cnt_base;
      end else if (cnt_eff == CNT_TWO) begin
        // Second release: double click when still inside the window
        flags.dbl = in_window;
        flags.up  = ~in_window;
        cnt_nxt   = CNT_ZERO;
      end
    end
  end

  // Lane state, updated on each accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      cnt_r   <= CNT_ZERO;
      first_r <= '0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

FILE: src/bedc_merge.sv
// ----------------------------------------------------------------------------
// bedc_merge
// Gathers lane findings into one result and holds it in a two-entry
// output buffer (output register plus skid register).
// ----------------------------------------------------------------------------
module bedc_merge
  import bedc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  lane_flags_t flags [LEVEL_WIDTH],
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data
);

  out_req_t merged;
  out_req_t main_r, main_nxt;
  out_req_t skid_r, skid_nxt;
  logic     main_v_r, main_v_nxt;
  logic     skid_v_r, skid_v_nxt;
  logic     take;

  // Combine lane bits into masks
  always_comb begin
    for (int i = 0; i < LEVEL_WIDTH; i++) begin
      merged.down_mask[i]         = flags[i].down;
      merged.up_mask[i]           = flags[i].up;
      merged.held_mask[i]         = flags[i].held;
      merged.double_click_mask[i] = flags[i].dbl;
    end
  end

  assign take = main_v_r & ~out_stall;

  // Buffer control
  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (take) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!main_v_r || take) begin
        main_nxt   = merged;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = merged;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      main_v_nxt = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

FILE: src/button_edge_double_click_detector.sv
// ----------------------------------------------------------------------------
// button_edge_double_click_detector
// Per-button press/release/held detection with double-click recognition.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one request per sample
//   tick with the button levels and a wrapping millisecond timestamp.
//   Result channel (out_valid / out_stall / out_data): one request per
//   accepted sample with down, up, held and double-click masks.
//   APB port: register 0 at byte address 0 is the double-click window
//   (reset 500); write only while the block is idle.
//   Throughput: one sample per cycle while in_stall is low; every button
//   lane decides its edge, count and timestamp in the same cycle, and the
//   merge stage registers the result.
//   Stall: a two-entry output buffer lets one more sample in while a result
//   waits; in_stall rises only once both entries are full.
//   Reset: levels, click counts, timestamps and buffer are cleared, and the
//   window returns to 500. Lanes above NUM_BUTTONS (or above 8) report zero.
// ----------------------------------------------------------------------------
module button_edge_double_click_detector
  import bedc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  // Result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned LANES = (NUM_BUTTONS < LEVEL_WIDTH) ? NUM_BUTTONS : LEVEL_WIDTH;

  logic [TIME_WIDTH-1:0] window_r;
  logic                  accept;
  logic                  full;
  lane_flags_t           flags [LEVEL_WIDTH];

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW) ? window_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW)) begin
      window_r <= pwdata;
    end
  end

  // Input handshake
  assign in_stall = full;
  assign accept   = in_valid & ~full;

  // Button lanes
  for (genvar g = 0; g < LEVEL_WIDTH; g++) begin : g_lane
    if (g < LANES) begin : g_on
      bedc_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .level    (in_data.button_levels[g]),
        .now_time (in_data.now_time),
        .window   (window_r),
        .flags    (flags[g])
      );
    end else begin : g_off
      assign flags[g] = '0;
    end
  end

  // Merge and output buffer
  bedc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .flags     (flags),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
